// ===== rtl/hgcd_pkg.sv =====
package hgcd_pkg;

  // CORDIC length, shared by the rotation and the vectoring units
  localparam int ITERS = 24;
  // integer square root of a 61-bit radicand: one result bit per stage
  localparam int ISQ_STEPS = 31;
  // divide-by-45 for the radian conversion: stages and quotient bits per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS = 8;
  // sincos: reduce, scale, divide, CORDIC, fold
  localparam int SC_LATENCY = ITERS + DIV_STAGES + 3;
  // whole block, input register to result strobe
  localparam int LATENCY = 1 + SC_LATENCY + 3 + ISQ_STEPS + 1 + ISQ_STEPS + ITERS + 2;

  // floor(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
  };

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] TURN_Q23 = 32'd3019898880;
  localparam logic [31:0] QUARTER_Q23 = 32'd754974720;
  localparam logic [31:0] HALF_Q23 = 32'd1509949440;
  localparam logic [31:0] THREE_Q_Q23 = 32'd2264924160;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  // half of 180 degrees in Q23, rounding term of the radian conversion
  localparam logic [61:0] RAD_ROUND = 62'd754974720;
  // 180 deg Q23 = 45 * 2^25: shift by 25, then divide by 45
  localparam int RAD_SHIFT = 25;
  localparam logic [6:0] DIV_K = 7'd45;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic [32:0] DIST_MAX = 33'd6746518852;
  localparam logic [31:0] DIAM_RESET = 32'd835059712;

  // register index decoded from paddr[2]
  localparam logic REG_SPHERE_DIAMETER = 1'b0;

  typedef logic signed [31:0] angle_t;
  typedef logic signed [31:0] unit_t;
  typedef logic signed [33:0] cxy_t;
  typedef logic signed [32:0] cz_t;

endpackage

// ===== rtl/haversine_great_circle_distance_core.sv =====
// Haversine great-circle distance, fully pipelined.
//
// Input: pulse start with the two points on first_/second_latitude and
// first_/second_longitude (signed degrees, 22 fraction bits). A transaction
// is taken at each rising edge with start high and busy low; busy is high
// only during reset, so one transaction per clock is sustained.
// Output: done is high for one cycle with distance (km, 16 fraction bits,
// saturating) for each input transaction. The pipeline is made of the
// radian conversion and divide-by-45, 24 rotation CORDIC stages, product
// stages, two 31-stage square roots, 24 vectoring CORDIC stages and the
// final scaling by the diameter.
// Results leave in input order; the receiver cannot stall and none is
// needed, since every stage advances each cycle.
// APB port: sphere_diameter at address 0 (reset 2*6371 km); write it only
// while no transaction is in flight. pready is always high.
// Reset (rst, synchronous) clears all valid bits, dropping work in flight.
module haversine_great_circle_distance_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [29:0] first_latitude,
  input  logic signed [30:0] first_longitude,
  input  logic signed [29:0] second_latitude,
  input  logic signed [30:0] second_longitude,
  output logic               done,
  output logic [32:0]        distance,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration register
  logic [31:0] sphere_diameter;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hgcd_pkg::REG_SPHERE_DIAMETER) ? sphere_diameter : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_diameter <= hgcd_pkg::DIAM_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == hgcd_pkg::REG_SPHERE_DIAMETER) begin
      sphere_diameter <= pwdata;
    end
  end

  assign busy = rst;

  // input stage: angle differences (half angles read as Q23) and doubled latitudes
  logic             v0;
  hgcd_pkg::angle_t ang_dlat;
  hgcd_pkg::angle_t ang_dlon;
  hgcd_pkg::angle_t ang_lat1;
  hgcd_pkg::angle_t ang_lat2;

  always_ff @(posedge clk) begin
    v0 <= rst ? 1'b0 : (start && !busy);
    ang_dlat <= 32'(first_latitude) - 32'(second_latitude);
    ang_dlon <= 32'(first_longitude) - 32'(second_longitude);
    ang_lat1 <= {first_latitude[29], first_latitude, 1'b0};
    ang_lat2 <= {second_latitude[29], second_latitude, 1'b0};
  end

  // four sin/cos lanes in lockstep
  logic            sc_v;
  logic            sc_v1;
  logic            sc_v2;
  logic            sc_v3;
  hgcd_pkg::unit_t s_lat;
  hgcd_pkg::unit_t s_lon;
  hgcd_pkg::unit_t c1;
  hgcd_pkg::unit_t c2;

  hgcd_sincos u_sc_dlat (
    .clk(clk), .rst(rst), .in_valid(v0), .angle(ang_dlat), .use_cos(1'b0),
    .out_valid(sc_v), .value(s_lat)
  );
  hgcd_sincos u_sc_dlon (
    .clk(clk), .rst(rst), .in_valid(v0), .angle(ang_dlon), .use_cos(1'b0),
    .out_valid(sc_v1), .value(s_lon)
  );
  hgcd_sincos u_sc_lat1 (
    .clk(clk), .rst(rst), .in_valid(v0), .angle(ang_lat1), .use_cos(1'b1),
    .out_valid(sc_v2), .value(c1)
  );
  hgcd_sincos u_sc_lat2 (
    .clk(clk), .rst(rst), .in_valid(v0), .angle(ang_lat2), .use_cos(1'b1),
    .out_valid(sc_v3), .value(c2)
  );

  // P1: squares of the sines and the cosine product
  logic signed [63:0] p_lat;
  logic signed [63:0] p_lon;
  logic signed [63:0] p_cc;
  logic               vp1;
  logic [30:0]        slat2;
  logic [30:0]        slon2;
  hgcd_pkg::unit_t    cc;

  assign p_lat = 64'(s_lat) * 64'(s_lat);
  assign p_lon = 64'(s_lon) * 64'(s_lon);
  assign p_cc = 64'(c1) * 64'(c2);

  always_ff @(posedge clk) begin
    vp1 <= rst ? 1'b0 : (sc_v && sc_v1 && sc_v2 && sc_v3);
    slat2 <= p_lat[60:30];
    slon2 <= p_lon[60:30];
    cc <= p_cc[61:30];
  end

  // P2: cos(lat1)cos(lat2) sin^2(dlon/2)
  logic signed [64:0] p_t;
  logic               vp2;
  logic [30:0]        slat2_d;
  hgcd_pkg::unit_t    t_term;

  assign p_t = 65'(cc) * $signed({34'd0, slon2});

  always_ff @(posedge clk) begin
    vp2 <= rst ? 1'b0 : vp1;
    slat2_d <= slat2;
    t_term <= p_t[61:30];
  end

  // P3: haversine term, clamped to [0, 1]
  logic signed [32:0] a_sum;
  logic [30:0]        a_clamp;
  logic               vp3;
  logic [30:0]        a_q;

  assign a_sum = 33'(t_term) + $signed({2'b00, slat2_d});

  always_comb begin
    if (a_sum < 0) begin
      a_clamp = 31'd0;
    end else if (a_sum > hgcd_pkg::ONE_Q30) begin
      a_clamp = 31'(hgcd_pkg::ONE_Q30);
    end else begin
      a_clamp = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    vp3 <= rst ? 1'b0 : vp2;
    a_q <= a_clamp;
  end

  // h = sqrt(a)
  logic        vh;
  logic [30:0] h_root;
  logic [30:0] h_tag;
  logic [30:0] h;

  hgcd_isqrt u_sqrt_h (
    .clk(clk), .rst(rst), .in_valid(vp3), .radicand({a_q, 30'd0}), .tag_in(31'd0),
    .out_valid(vh), .root(h_root), .tag_out(h_tag)
  );

  assign h = (h_root > 31'(hgcd_pkg::ONE_Q30)) ? 31'(hgcd_pkg::ONE_Q30) : (h_root | h_tag);

  // Q1: 1 - h^2 for the cosine side of asin
  logic [61:0] h_sq;
  logic [61:0] n_cos;
  logic        vq1;
  logic [60:0] n_cos_q;
  logic [30:0] h_q;

  assign h_sq = 62'(h) * 62'(h);
  assign n_cos = (62'(1) << 60) - h_sq;

  always_ff @(posedge clk) begin
    vq1 <= rst ? 1'b0 : vh;
    n_cos_q <= n_cos[60:0];
    h_q <= h;
  end

  // g = sqrt(1 - h^2), h travels alongside
  logic        vg;
  logic [30:0] g;
  logic [30:0] h_d;

  hgcd_isqrt u_sqrt_g (
    .clk(clk), .rst(rst), .in_valid(vq1), .radicand(n_cos_q), .tag_in(h_q),
    .out_valid(vg), .root(g), .tag_out(h_d)
  );

  // theta = atan2(h, g) = asin(h)
  logic        vt;
  logic [30:0] theta;

  hgcd_vector u_asin (
    .clk(clk), .rst(rst), .in_valid(vg), .x_in(g), .y_in(h_d),
    .out_valid(vt), .theta(theta)
  );

  // M1: diameter times angle
  logic        vm1;
  logic [62:0] d_prod;

  always_ff @(posedge clk) begin
    vm1 <= rst ? 1'b0 : vt;
    d_prod <= 63'(sphere_diameter) * 63'(theta);
  end

  // M2: round, saturate, deliver
  logic [63:0] d_round;
  logic [33:0] d_wide;

  assign d_round = 64'(d_prod) + (64'(1) << 29);
  assign d_wide = d_round[63:30];

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : vm1;
    distance <= (d_wide > 34'(hgcd_pkg::DIST_MAX)) ? hgcd_pkg::DIST_MAX : d_wide[32:0];
  end

  // every accepted transaction yields a result after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hgcd_pkg::LATENCY) done)
    else $error("result missing after accepted transaction");

  // no result without a matching transaction
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hgcd_pkg::LATENCY))
    else $error("result without matching transaction");

  // the sin/cos lanes stay in lockstep
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    (sc_v == sc_v1) && (sc_v == sc_v2) && (sc_v == sc_v3))
    else $error("sin/cos lanes out of step");

  // saturation holds
  a_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> (distance <= hgcd_pkg::DIST_MAX))
    else $error("distance above saturation limit");

endmodule

// ===== rtl/hgcd_sincos.sv =====
module hgcd_sincos (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hgcd_pkg::angle_t   angle,
  input  logic               use_cos,
  output logic               out_valid,
  output hgcd_pkg::unit_t    value
);

  // stage A: reduce to [0,360) degrees, split into quadrant and remainder
  logic [33:0] r_wide;
  logic [31:0] r_red;
  logic [1:0]  quad_a;
  logic [31:0] off_a;
  logic        va;
  logic [1:0]  quad_a_q;
  logic [29:0] rem_a_q;

  assign r_wide = {{2{angle[31]}}, angle} + (angle[31] ? {2'b00, hgcd_pkg::TURN_Q23} : 34'd0);
  assign r_red = r_wide[31:0];

  always_comb begin
    priority if (r_red >= hgcd_pkg::THREE_Q_Q23) begin
      quad_a = 2'd3;
      off_a = hgcd_pkg::THREE_Q_Q23;
    end else if (r_red >= hgcd_pkg::HALF_Q23) begin
      quad_a = 2'd2;
      off_a = hgcd_pkg::HALF_Q23;
    end else if (r_red >= hgcd_pkg::QUARTER_Q23) begin
      quad_a = 2'd1;
      off_a = hgcd_pkg::QUARTER_Q23;
    end else begin
      quad_a = 2'd0;
      off_a = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    va <= rst ? 1'b0 : in_valid;
    quad_a_q <= quad_a;
    rem_a_q <= 30'(r_red - off_a);
  end

  // stage B: scale by pi, add rounding term, drop the power-of-two part of 180 deg
  logic [61:0] prod_b;
  logic        vb;
  logic [1:0]  quad_b;
  logic [36:0] m_b;

  assign prod_b = 62'(rem_a_q) * 62'(hgcd_pkg::PI_Q30) + hgcd_pkg::RAD_ROUND;

  always_ff @(posedge clk) begin
    vb <= rst ? 1'b0 : va;
    quad_b <= quad_a_q;
    m_b <= prod_b[61:hgcd_pkg::RAD_SHIFT];
  end

  // stage C: restoring divide by 45, a few quotient bits per stage
  logic        dv    [hgcd_pkg::DIV_STAGES];
  logic [1:0]  dquad [hgcd_pkg::DIV_STAGES];
  logic [5:0]  drem  [hgcd_pkg::DIV_STAGES];
  logic [31:0] dbits [hgcd_pkg::DIV_STAGES];
  logic [31:0] dq    [hgcd_pkg::DIV_STAGES];

  for (genvar k = 0; k < hgcd_pkg::DIV_STAGES; k++) begin : g_div
    logic        vi;
    logic [1:0]  qi;
    logic [5:0]  ri;
    logic [31:0] bi;
    logic [31:0] qoi;
    logic [5:0]  rn;
    logic [31:0] bn;
    logic [31:0] qn;

    if (k == 0) begin : g_first
      assign vi = vb;
      assign qi = quad_b;
      assign ri = {1'b0, m_b[36:32]};
      assign bi = m_b[31:0];
      assign qoi = 32'd0;
    end else begin : g_next
      assign vi = dv[k-1];
      assign qi = dquad[k-1];
      assign ri = drem[k-1];
      assign bi = dbits[k-1];
      assign qoi = dq[k-1];
    end

    always_comb begin
      logic [6:0] r7;
      rn = ri;
      bn = bi;
      qn = qoi;
      for (int j = 0; j < hgcd_pkg::DIV_BITS; j++) begin
        r7 = {rn, bn[31]};
        bn = {bn[30:0], 1'b0};
        if (r7 >= hgcd_pkg::DIV_K) begin
          rn = 6'(r7 - hgcd_pkg::DIV_K);
          qn = {qn[30:0], 1'b1};
        end else begin
          rn = r7[5:0];
          qn = {qn[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      dv[k] <= rst ? 1'b0 : vi;
      dquad[k] <= qi;
      drem[k] <= rn;
      dbits[k] <= bn;
      dq[k] <= qn;
    end
  end

  // stage D: rotation CORDIC, one iteration per stage
  logic               cv    [hgcd_pkg::ITERS];
  logic [1:0]         cquad [hgcd_pkg::ITERS];
  hgcd_pkg::cxy_t     cx    [hgcd_pkg::ITERS];
  hgcd_pkg::cxy_t     cy    [hgcd_pkg::ITERS];
  hgcd_pkg::cz_t      cz    [hgcd_pkg::ITERS];

  for (genvar i = 0; i < hgcd_pkg::ITERS; i++) begin : g_rot
    logic           vi;
    logic [1:0]     qi;
    hgcd_pkg::cxy_t xi;
    hgcd_pkg::cxy_t yi;
    hgcd_pkg::cz_t  zi;
    hgcd_pkg::cz_t  at;

    if (i == 0) begin : g_first
      assign vi = dv[hgcd_pkg::DIV_STAGES-1];
      assign qi = dquad[hgcd_pkg::DIV_STAGES-1];
      assign xi = hgcd_pkg::GAIN_Q30;
      assign yi = '0;
      assign zi = $signed({1'b0, dq[hgcd_pkg::DIV_STAGES-1]});
    end else begin : g_next
      assign vi = cv[i-1];
      assign qi = cquad[i-1];
      assign xi = cx[i-1];
      assign yi = cy[i-1];
      assign zi = cz[i-1];
    end

    assign at = $signed({1'b0, hgcd_pkg::ATAN_Q30[i]});

    always_ff @(posedge clk) begin
      cv[i] <= rst ? 1'b0 : vi;
      cquad[i] <= qi;
      if (zi >= 0) begin
        cx[i] <= xi - (yi >>> i);
        cy[i] <= yi + (xi >>> i);
        cz[i] <= zi - at;
      end else begin
        cx[i] <= xi + (yi >>> i);
        cy[i] <= yi - (xi >>> i);
        cz[i] <= zi + at;
      end
    end
  end

  // stage E: clamp to the unit range and fold the quadrant back in
  hgcd_pkg::cxy_t  fx;
  hgcd_pkg::cxy_t  fy;
  hgcd_pkg::unit_t s_c;
  hgcd_pkg::unit_t c_c;
  hgcd_pkg::unit_t sel;

  assign fx = cx[hgcd_pkg::ITERS-1];
  assign fy = cy[hgcd_pkg::ITERS-1];

  always_comb begin
    if (fy > 34'(hgcd_pkg::ONE_Q30)) begin
      s_c = 32'(hgcd_pkg::ONE_Q30);
    end else if (fy < -34'(hgcd_pkg::ONE_Q30)) begin
      s_c = -32'(hgcd_pkg::ONE_Q30);
    end else begin
      s_c = fy[31:0];
    end
    if (fx > 34'(hgcd_pkg::ONE_Q30)) begin
      c_c = 32'(hgcd_pkg::ONE_Q30);
    end else if (fx < -34'(hgcd_pkg::ONE_Q30)) begin
      c_c = -32'(hgcd_pkg::ONE_Q30);
    end else begin
      c_c = fx[31:0];
    end
    unique case (cquad[hgcd_pkg::ITERS-1])
      2'd0:    sel = use_cos ? c_c : s_c;
      2'd1:    sel = use_cos ? -s_c : c_c;
      2'd2:    sel = use_cos ? -c_c : -s_c;
      default: sel = use_cos ? s_c : -c_c;
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid <= rst ? 1'b0 : cv[hgcd_pkg::ITERS-1];
    value <= sel;
  end

endmodule

// ===== rtl/hgcd_isqrt.sv =====
module hgcd_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [60:0] radicand,
  input  logic [30:0] tag_in,
  output logic        out_valid,
  output logic [30:0] root,
  output logic [30:0] tag_out
);

  // digit-by-digit floor square root, one result bit per stage
  logic        sv   [hgcd_pkg::ISQ_STEPS];
  logic [61:0] sn   [hgcd_pkg::ISQ_STEPS];
  logic [61:0] sres [hgcd_pkg::ISQ_STEPS];
  logic [30:0] stag [hgcd_pkg::ISQ_STEPS];

  for (genvar k = 0; k < hgcd_pkg::ISQ_STEPS; k++) begin : g_step
    localparam logic [61:0] BIT = 62'(1) << (2 * (hgcd_pkg::ISQ_STEPS - 1 - k));
    logic        vi;
    logic [61:0] ni;
    logic [61:0] ri;
    logic [30:0] ti;
    logic [61:0] trial;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ni = {1'b0, radicand};
      assign ri = '0;
      assign ti = tag_in;
    end else begin : g_next
      assign vi = sv[k-1];
      assign ni = sn[k-1];
      assign ri = sres[k-1];
      assign ti = stag[k-1];
    end

    assign trial = ri + BIT;

    always_ff @(posedge clk) begin
      sv[k] <= rst ? 1'b0 : vi;
      stag[k] <= ti;
      if (ni >= trial) begin
        sn[k] <= ni - trial;
        sres[k] <= (ri >> 1) + BIT;
      end else begin
        sn[k] <= ni;
        sres[k] <= ri >> 1;
      end
    end
  end

  assign out_valid = sv[hgcd_pkg::ISQ_STEPS-1];
  assign root = sres[hgcd_pkg::ISQ_STEPS-1][30:0];
  assign tag_out = stag[hgcd_pkg::ISQ_STEPS-1];

endmodule

// ===== rtl/hgcd_vector.sv =====
module hgcd_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [30:0] x_in,
  input  logic [30:0] y_in,
  output logic        out_valid,
  output logic [30:0] theta
);

  // vectoring CORDIC, one iteration per stage, accumulates atan2(y, x)
  logic           vv [hgcd_pkg::ITERS];
  hgcd_pkg::cxy_t vx [hgcd_pkg::ITERS];
  hgcd_pkg::cxy_t vy [hgcd_pkg::ITERS];
  hgcd_pkg::cz_t  vz [hgcd_pkg::ITERS];

  for (genvar i = 0; i < hgcd_pkg::ITERS; i++) begin : g_vec
    logic           vi;
    hgcd_pkg::cxy_t xi;
    hgcd_pkg::cxy_t yi;
    hgcd_pkg::cz_t  zi;
    hgcd_pkg::cz_t  at;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = $signed({3'b000, x_in});
      assign yi = $signed({3'b000, y_in});
      assign zi = '0;
    end else begin : g_next
      assign vi = vv[i-1];
      assign xi = vx[i-1];
      assign yi = vy[i-1];
      assign zi = vz[i-1];
    end

    assign at = $signed({1'b0, hgcd_pkg::ATAN_Q30[i]});

    always_ff @(posedge clk) begin
      vv[i] <= rst ? 1'b0 : vi;
      if (yi >= 0) begin
        vx[i] <= xi + (yi >>> i);
        vy[i] <= yi - (xi >>> i);
        vz[i] <= zi + at;
      end else begin
        vx[i] <= xi - (yi >>> i);
        vy[i] <= yi + (xi >>> i);
        vz[i] <= zi - at;
      end
    end
  end

  // round-off can leave a tiny negative angle: take it as zero
  assign out_valid = vv[hgcd_pkg::ITERS-1];
  assign theta = vz[hgcd_pkg::ITERS-1][32] ? 31'd0 : vz[hgcd_pkg::ITERS-1][30:0];

endmodule
